FILE: design/ip6tap_pkg.sv
// ============================================================================
// ip6tap_pkg: shared types and constants for the IPv6 text address parser
// Character codes, segment phase encoding, word geometry and the hex digit
// decoder used by the parser datapath.
// ============================================================================
package ip6tap_pkg;

    // Address geometry: eight 16-bit words.
    localparam int WORD_COUNT = 8;
    localparam int WORD_W     = 16;
    localparam int IDX_W      = $clog2(WORD_COUNT) + 1;
    localparam int SEL_W      = $clog2(WORD_COUNT);

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Where the parser stands inside one segment.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_COMMA  = 3'd1,
        PH_QUOTE  = 3'd2,
        PH_HEX    = 3'd3,
        PH_TCOMMA = 3'd4,
        PH_COLON  = 3'd5
    } phase_t;

    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] word_vec_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decodes 0-9, a-f and A-F; anything else is not a digit.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: design/ipv6_text_address_parser.sv
// ============================================================================
// ipv6_text_address_parser: IPv6 text to 128-bit address converter
// Consumes one character per request and returns the binary address with
// the zero gap expanded, or a failure flag on a second gap.
// ============================================================================
// The parser takes one character per request and sustains one request per
// clock cycle while no result waits to be taken. Each request passes
// through an input register, combinational per-character logic that
// updates the parse state, and an output register that holds the result;
// the result is loaded into the output register as the input register
// advances into a free output stage. Set start_req on the
// first character of an address; a start_req in the middle of an address
// abandons that address without a result. Characters without start_req
// while no address is open are dropped. A result appears only for the
// character that ends the address: a NUL or a quote at the start of a
// segment, the close of the eighth segment, or a second empty segment (a
// second "::" gap, reported with ok low and the words gathered so far,
// unexpanded). char_taken tells the source whether that ending character
// belongs to the address. The input register advances only into a free
// output stage, so while a result waits to be taken one more character is
// accepted into the input register and the input then stalls until the
// result is taken.
// ============================================================================
module ipv6_text_address_parser
    import ip6tap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low,
    output logic        char_taken
);

    // Input register.
    logic             s0_valid_reg;
    logic             s0_start_reg;
    logic [7:0]       s0_ch_reg;

    // Parse state.
    word_vec_t        words_reg;
    word_vec_t        words_next;
    logic [IDX_W-1:0] widx_reg;
    logic [IDX_W-1:0] widx_next;
    logic [IDX_W-1:0] gidx_reg;
    logic [IDX_W-1:0] gidx_next;
    logic             gap_reg;
    logic             gap_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic             segc_reg;
    logic             segc_next;
    logic             skip_reg;
    logic             skip_next;
    logic             busy_reg;
    logic             busy_next;

    // Result of the character in the input register.
    logic             res_valid;
    logic             res_ok;
    logic             res_taken;
    word_vec_t        res_words;

    // Output register.
    logic             out_valid_reg;
    logic             ok_reg;
    logic             taken_reg;
    logic [63:0]      addr_high_reg;
    logic [63:0]      addr_low_reg;

    logic             out_free;
    logic             s0_adv;

    assign out_free = !out_valid_reg || out_ready;
    assign s0_adv   = s0_valid_reg && out_free;
    assign in_ready = !s0_valid_reg || out_free;

    // ------------------------------------------------------------------------
    // Per-character step. A character that no phase consumes closes the
    // segment and is then offered to the next segment. At most three closes
    // can happen for one character: a filled segment, an empty one that
    // opens the gap, and an empty one that fails.
    // ------------------------------------------------------------------------
    always_comb
    begin : char_step
        logic             active;
        logic             is_nul;
        logic             is_quote;
        logic             is_comma;
        logic             is_colon;
        hex_digit_t       hd;
        logic             need_close;
        logic             at_start;
        logic             fin;
        logic             fin_ok;
        logic             fin_taken;
        logic [IDX_W-1:0] w_idx;
        logic [IDX_W-1:0] g_idx;
        logic             gap;
        logic [WORD_W-1:0] acc;
        phase_t           ph;
        logic             segc;
        logic             skip;
        logic             busy;
        word_vec_t        wv;

        active   = s0_start_reg || busy_reg;
        is_nul   = (s0_ch_reg == CH_NUL);
        is_quote = (s0_ch_reg == CH_QUOTE);
        is_comma = (s0_ch_reg == CH_COMMA);
        is_colon = (s0_ch_reg == CH_COLON);
        hd       = hex_decode(s0_ch_reg);

        if (s0_start_reg)
        begin
            w_idx = '0;
            g_idx = '0;
            gap   = 1'b0;
            acc   = '0;
            ph    = PH_START;
            segc  = 1'b0;
            skip  = 1'b0;
            busy  = 1'b1;
            wv    = '0;
        end
        else
        begin
            w_idx = widx_reg;
            g_idx = gidx_reg;
            gap   = gap_reg;
            acc   = acc_reg;
            ph    = phase_reg;
            segc  = segc_reg;
            skip  = skip_reg;
            busy  = busy_reg;
            wv    = words_reg;
        end

        need_close = 1'b0;
        at_start   = 1'b0;
        fin        = 1'b0;
        fin_ok     = 1'b1;
        fin_taken  = 1'b0;

        // First pass from the stored phase.
        if (active)
        begin
            case (ph)
                PH_START:
                begin
                    at_start = 1'b1;
                end
                PH_COMMA:
                begin
                    if (is_comma)
                    begin
                        ph   = PH_QUOTE;
                        segc = 1'b1;
                    end
                    else if (is_quote)
                    begin
                        ph   = PH_HEX;
                        segc = 1'b1;
                    end
                    else if (hd.valid)
                    begin
                        ph   = PH_HEX;
                        acc  = {acc[WORD_W-5:0], hd.value};
                        segc = 1'b1;
                    end
                    else
                    begin
                        need_close = 1'b1;
                    end
                end
                PH_QUOTE:
                begin
                    if (is_quote || hd.valid)
                    begin
                        ph   = PH_HEX;
                        segc = 1'b1;
                        if (hd.valid)
                        begin
                            acc = {acc[WORD_W-5:0], hd.value};
                        end
                    end
                    else if (is_comma)
                    begin
                        ph   = PH_COLON;
                        segc = 1'b1;
                    end
                    else
                    begin
                        need_close = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    if (hd.valid)
                    begin
                        acc  = {acc[WORD_W-5:0], hd.value};
                        segc = 1'b1;
                    end
                    else if (is_comma)
                    begin
                        ph   = PH_COLON;
                        segc = 1'b1;
                    end
                    else
                    begin
                        need_close = 1'b1;
                    end
                end
                PH_TCOMMA:
                begin
                    if (is_comma)
                    begin
                        ph   = PH_COLON;
                        segc = 1'b1;
                    end
                    else
                    begin
                        need_close = 1'b1;
                    end
                end
                default:
                begin
                    need_close = 1'b1;
                end
            endcase
        end

        for (int k = 0; k < 4; k++)
        begin
            if (active && !fin && need_close)
            begin
                need_close = 1'b0;
                if (!segc)
                begin
                    if (gap)
                    begin
                        fin       = 1'b1;
                        fin_ok    = 1'b0;
                        fin_taken = is_colon;
                    end
                    else
                    begin
                        gap   = 1'b1;
                        g_idx = w_idx;
                        if (w_idx == '0)
                        begin
                            skip = 1'b1;
                        end
                    end
                end
                else
                begin
                    wv[w_idx[SEL_W-1:0]] = acc;
                end
                if (!fin)
                begin
                    w_idx = w_idx + IDX_W'(1);
                    acc   = '0;
                    segc  = 1'b0;
                    ph    = PH_START;
                    if (w_idx[IDX_W-1])
                    begin
                        fin       = 1'b1;
                        fin_taken = is_colon;
                    end
                    else if (!is_colon)
                    begin
                        at_start = 1'b1;
                    end
                end
            end
            // Opening of a segment: ends, drops the character after a leading gap,
            // routes it to the quote or hex phase, or closes the segment.
            if (active && !fin && at_start)
            begin
                at_start = 1'b0;
                if (skip)
                begin
                    if (is_nul)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        skip = 1'b0;
                    end
                end
                else if (is_nul || is_quote)
                begin
                    fin = 1'b1;
                end
                else if (is_comma)
                begin
                    ph   = PH_QUOTE;
                    segc = 1'b1;
                end
                else if (hd.valid)
                begin
                    ph   = PH_HEX;
                    acc  = {acc[WORD_W-5:0], hd.value};
                    segc = 1'b1;
                end
                else
                begin
                    need_close = 1'b1;
                end
            end
        end

        if (fin)
        begin
            busy = 1'b0;
        end

        widx_next  = w_idx;
        gidx_next  = g_idx;
        gap_next   = gap;
        acc_next   = acc;
        phase_next = ph;
        segc_next  = segc;
        skip_next  = skip;
        busy_next  = busy;
        words_next = wv;
        res_valid  = fin;
        res_ok     = fin_ok;
        res_taken  = fin_taken;
    end

    // ------------------------------------------------------------------------
    // Gap expansion. The words after the gap are rotated to the tail and the
    // words between the gap and them read as zero.
    // ------------------------------------------------------------------------
    always_comb
    begin : gap_expand
        logic [SEL_W-1:0]   g;
        logic [SEL_W-1:0]   move;
        logic [IDX_W-1:0]   endi;
        logic [SEL_W-1:0]   rot;
        logic [2*WORD_COUNT*WORD_W-1:0] dbl;
        word_vec_t          rv;

        g    = gidx_next[SEL_W-1:0];
        move = (widx_next > {1'b0, g}) ? SEL_W'(widx_next - {1'b0, g} - IDX_W'(1))
                                       : '0;
        endi = IDX_W'(WORD_COUNT) - {1'b0, move};
        rot  = move + g + SEL_W'(1);
        dbl  = {words_next, words_next} >> ({rot, 4'b0000});
        rv   = dbl[WORD_COUNT*WORD_W-1:0];

        res_words = words_next;
        if (res_ok && gap_next)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                if (IDX_W'(i) <= {1'b0, g})
                begin
                    res_words[i] = words_next[i];
                end
                else if (IDX_W'(i) < endi)
                begin
                    res_words[i] = '0;
                end
                else
                begin
                    res_words[i] = rv[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            widx_reg      <= '0;
            gidx_reg      <= '0;
            gap_reg       <= 1'b0;
            phase_reg     <= PH_START;
            segc_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s0_valid_reg && res_valid;
            end
            if (s0_adv)
            begin
                widx_reg  <= widx_next;
                gidx_reg  <= gidx_next;
                gap_reg   <= gap_next;
                phase_reg <= phase_next;
                segc_reg  <= segc_next;
                skip_reg  <= skip_next;
                busy_reg  <= busy_next;
            end
        end
    end

    // Payload registers; a start request clears the words and accumulator.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_start_reg <= start_req;
            s0_ch_reg    <= ch;
        end
        if (s0_adv)
        begin
            words_reg <= words_next;
            acc_reg   <= acc_next;
        end
        if (s0_adv && res_valid)
        begin
            ok_reg        <= res_ok;
            taken_reg     <= res_taken;
            addr_high_reg <= {res_words[0], res_words[1], res_words[2], res_words[3]};
            addr_low_reg  <= {res_words[4], res_words[5], res_words[6], res_words[7]};
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign char_taken = taken_reg;
    assign addr_high  = addr_high_reg;
    assign addr_low   = addr_low_reg;

endmodule
